// ===== rtl/linear_interp_resampler_core_assert.svh =====
// assertion macros for the linear interpolation resampler
// used by rtl modules that check their own control logic
`ifndef LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lir assertion failed");
// next-cycle implication
`define LIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lir assertion failed");
`else
`define LIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/lir_pkg.sv =====
// shared types for the linear interpolation resampler
// no dependencies
package lir_pkg;

  typedef struct packed {
    logic valid;
    logic last;
    logic stereo;
  } lir_ctrl_t;

endpackage

// ===== rtl/lir_lane.sv =====
// one channel lane: difference times fraction, registered
// no package dependencies
module lir_lane #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [SAMPLE_BITS-1:0]         s0,
  input  logic signed [SAMPLE_BITS-1:0]         s1,
  input  logic        [FRAC_BITS-1:0]           frac,
  output logic signed [SAMPLE_BITS-1:0]         base_r,
  output logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_r
);

  logic signed [SAMPLE_BITS:0]             diff;
  logic signed [FRAC_BITS:0]               frac_s;
  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_nxt;

  assign diff     = {s1[SAMPLE_BITS-1], s1} - {s0[SAMPLE_BITS-1], s0};
  assign frac_s   = {1'b0, frac};
  assign prod_nxt = diff * frac_s;

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= s0;
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== rtl/lir_merge.sv =====
// merge stage: adds lane products to base samples, output register
// depends on lir_pkg
module lir_merge #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  lir_pkg::lir_ctrl_t                      iss_ctrl,
  input  logic signed [SAMPLE_BITS-1:0]           base_l,
  input  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_l,
  input  logic signed [SAMPLE_BITS-1:0]           base_rt,
  input  logic signed [SAMPLE_BITS+FRAC_BITS+1:0] prod_rt,
  output logic                                    en,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic        [SAMPLE_BITS-1:0]           out_left,
  output logic        [SAMPLE_BITS-1:0]           out_right,
  output logic                                    out_last
);
  import lir_pkg::*;

  localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

  lir_ctrl_t              ctrl1_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_left_r;
  logic [SAMPLE_BITS-1:0] out_right_r;
  logic                   out_last_r;
  logic [SAMPLE_BITS+1:0] sum_l;
  logic [SAMPLE_BITS+1:0] sum_rt;

  assign en = !out_valid_r || out_ready;

  assign sum_l  = {{2{base_l[SAMPLE_BITS-1]}}, base_l} + prod_l[PW-1:FRAC_BITS];
  assign sum_rt = {{2{base_rt[SAMPLE_BITS-1]}}, base_rt} + prod_rt[PW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctrl1_r     <= iss_ctrl;
      out_valid_r <= ctrl1_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_left_r  <= sum_l[SAMPLE_BITS-1:0];
      out_right_r <= ctrl1_r.stereo ? sum_rt[SAMPLE_BITS-1:0] : '0;
      out_last_r  <= ctrl1_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/lir_seq.sv =====
// sequencer: holds the previous frame and phase, issues one output position a cycle while en is high
// depends on lir_pkg and the assertion macro header
`include "linear_interp_resampler_core_assert.svh"

module lir_seq #(
  parameter int SAMPLE_BITS  = 16,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 8,
  parameter int STEP_W       = FRAC_BITS + $clog2(MAX_UPSAMPLE + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [STEP_W-1:0]             step_cfg,
  input  logic                          stereo_cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic                          in_last,
  output logic signed [SAMPLE_BITS-1:0] iss_s0_l,
  output logic signed [SAMPLE_BITS-1:0] iss_s1_l,
  output logic signed [SAMPLE_BITS-1:0] iss_s0_r,
  output logic signed [SAMPLE_BITS-1:0] iss_s1_r,
  output logic [FRAC_BITS-1:0]          iss_frac,
  output lir_pkg::lir_ctrl_t            iss_ctrl
);
  import lir_pkg::*;

  localparam int ONE_I      = 1 << FRAC_BITS;
  localparam int STEP_MIN_I = (ONE_I + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
  localparam int STEP_MAX_I = ONE_I * MAX_UPSAMPLE;
  localparam logic [STEP_W-1:0] ONE_POS  = STEP_W'(ONE_I);
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(STEP_MIN_I);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEP_MAX_I);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INTERP,
    S_TAIL
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SAMPLE_BITS-1:0]  held_l_r, held_l_nxt;
  logic [SAMPLE_BITS-1:0]  held_r_r, held_r_nxt;
  logic [SAMPLE_BITS-1:0]  cur_l_r, cur_l_nxt;
  logic [SAMPLE_BITS-1:0]  cur_r_r, cur_r_nxt;
  logic [STEP_W-1:0]       phase_r, phase_nxt;
  logic                    have_held_r, have_held_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    stereo_r, stereo_nxt;
  logic                    last_r, last_nxt;

  logic                    iss_valid;
  logic                    iss_last;
  logic                    ph_lt_one;
  logic [STEP_W-1:0]       ph_sum;
  logic                    sum_lt_one;
  logic [STEP_W-1:0]       sum_wrap;
  logic                    wrap_lt_one;
  logic [SAMPLE_BITS-1:0]  in_r_eff;
  logic [STEP_W-1:0]       step_clamp;

  assign in_ready    = (state_r == S_IDLE);
  assign ph_lt_one   = phase_r < ONE_POS;
  assign ph_sum      = phase_r + step_r;
  assign sum_lt_one  = ph_sum < ONE_POS;
  assign sum_wrap    = ph_sum - ONE_POS;
  assign wrap_lt_one = sum_wrap < ONE_POS;
  assign in_r_eff    = stereo_cfg ? in_right : '0;

  always_comb begin
    priority if (step_cfg < STEP_MIN) begin
      step_clamp = STEP_MIN;
    end else if (step_cfg > STEP_MAX) begin
      step_clamp = STEP_MAX;
    end else begin
      step_clamp = step_cfg;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    held_l_nxt    = held_l_r;
    held_r_nxt    = held_r_r;
    cur_l_nxt     = cur_l_r;
    cur_r_nxt     = cur_r_r;
    phase_nxt     = phase_r;
    have_held_nxt = have_held_r;
    step_nxt      = step_r;
    stereo_nxt    = stereo_r;
    last_nxt      = last_r;
    iss_valid     = 1'b0;
    iss_last      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          step_nxt   = step_clamp;
          stereo_nxt = stereo_cfg;
          last_nxt   = in_last;
          cur_l_nxt  = in_left;
          cur_r_nxt  = in_r_eff;
          if (have_held_r) begin
            state_nxt = S_INTERP;
          end else begin
            phase_nxt     = '0;
            have_held_nxt = 1'b1;
            held_l_nxt    = in_left;
            held_r_nxt    = in_r_eff;
            if (in_last) begin
              state_nxt = S_TAIL;
            end
          end
        end
      end
      S_INTERP: begin
        if (ph_lt_one) begin
          if (en) begin
            iss_valid = 1'b1;
            if (sum_lt_one) begin
              phase_nxt = ph_sum;
            end else begin
              iss_last   = !(last_r && wrap_lt_one);
              phase_nxt  = sum_wrap;
              held_l_nxt = cur_l_r;
              held_r_nxt = cur_r_r;
              state_nxt  = last_r ? S_TAIL : S_IDLE;
            end
          end
        end else begin
          phase_nxt  = phase_r - ONE_POS;
          held_l_nxt = cur_l_r;
          held_r_nxt = cur_r_r;
          state_nxt  = last_r ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        if (ph_lt_one) begin
          if (en) begin
            iss_valid = 1'b1;
            phase_nxt = ph_sum;
            if (!sum_lt_one) begin
              iss_last      = 1'b1;
              held_l_nxt    = '0;
              held_r_nxt    = '0;
              phase_nxt     = '0;
              have_held_nxt = 1'b0;
              state_nxt     = S_IDLE;
            end
          end
        end else begin
          held_l_nxt    = '0;
          held_r_nxt    = '0;
          phase_nxt     = '0;
          have_held_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_l_r    <= '0;
      held_r_r    <= '0;
      phase_r     <= '0;
      have_held_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_l_r    <= held_l_nxt;
      held_r_r    <= held_r_nxt;
      phase_r     <= phase_nxt;
      have_held_r <= have_held_nxt;
    end
    cur_l_r  <= cur_l_nxt;
    cur_r_r  <= cur_r_nxt;
    step_r   <= step_nxt;
    stereo_r <= stereo_nxt;
    last_r   <= last_nxt;
  end

  assign iss_s0_l = held_l_r;
  assign iss_s1_l = cur_l_r;
  assign iss_s0_r = held_r_r;
  assign iss_s1_r = cur_r_r;
  assign iss_frac = phase_r[FRAC_BITS-1:0];
  assign iss_ctrl = '{valid: iss_valid, last: iss_last, stereo: stereo_r};

  `LIR_ASSERT_IMP(a_tail_flat, clk, rst_n, state_r == S_TAIL, (cur_l_r == held_l_r) && (cur_r_r == held_r_r))
  `LIR_ASSERT_IMP(a_step_range, clk, rst_n, state_r != S_IDLE, (step_r >= STEP_MIN) && (step_r <= STEP_MAX))
  `LIR_ASSERT_NXT(a_tail_done, clk, rst_n, iss_valid && iss_last && (state_r == S_TAIL), state_r == S_IDLE)
  `LIR_ASSERT_IMP(a_fresh_phase, clk, rst_n, (state_r == S_IDLE) && !have_held_r, phase_r == '0)

endmodule

// ===== rtl/linear_interp_resampler_core.sv =====
// Linear interpolation resampler for mono or stereo Q1.15 audio frames.
// Input frames arrive on in_t*, with in_tdata = {right, left} and in_tlast marking
// the final frame of a stream. Resampled frames leave on out_t*, out_tlast marking
// the last result caused by one input frame. cfg_* writes step_ratio (index 0,
// unsigned Q4.16 source over target rate) and channel_count (index 1); cfg_ready
// is always high and writes belong between streams.
// One frame is taken at a time and the sequencer issues one output position per cycle
// while the output is not stalled. A held frame is accepted in the idle state and its
// results are issued in the interpolate state; a last frame then issues its tail
// results in the tail state. The first frame of a stream only becomes the held frame,
// and goes on to its tail results when it is also last.
// out_tvalid follows an issued position through the lane multiply register and the
// merge output register. A held frame that gives no result issues nothing.
// Reset clears the held frame and phase, sets step to 1.0 and stereo.
// When out_tvalid is high and out_tready is low the lane and output stages freeze
// and no position is issued; in_tready stays high while the sequencer is idle.
// depends on lir_pkg, lir_seq, lir_lane, lir_merge
module linear_interp_resampler_core #(
  parameter int SAMPLE_BITS  = 16,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 8,
  localparam int STEP_W      = FRAC_BITS + $clog2(MAX_UPSAMPLE + 1),
  localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // sample_left, sample_right
  input  logic               in_tlast,   // last_frame
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // out_left, out_right
  output logic               out_tlast,  // run_last
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [STEP_W-1:0]  cfg_data
);
  import lir_pkg::*;

  localparam logic [1:0]        CFG_STEP_RATIO    = 2'd0;
  localparam logic [1:0]        CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [STEP_W-1:0] STEP_RESET        = STEP_W'(1 << FRAC_BITS);
  localparam int                PW                = SAMPLE_BITS + FRAC_BITS + 2;

  logic [STEP_W-1:0] step_cfg_r;
  logic [1:0]        chan_cfg_r;

  logic                          en;
  logic signed [SAMPLE_BITS-1:0] s0_l, s1_l, s0_r, s1_r;
  logic [FRAC_BITS-1:0]          frac;
  lir_ctrl_t                     iss_ctrl;
  logic signed [SAMPLE_BITS-1:0] base_l, base_rt;
  logic signed [PW-1:0]          prod_l, prod_rt;
  logic [SAMPLE_BITS-1:0]        res_l, res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cfg_r <= STEP_RESET;
      chan_cfg_r <= 2'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_RATIO:    step_cfg_r <= cfg_data;
        CFG_CHANNEL_COUNT: chan_cfg_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  lir_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE),
    .STEP_W      (STEP_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step_cfg  (step_cfg_r),
    .stereo_cfg(chan_cfg_r[1]),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_left   (in_tdata[SAMPLE_BITS-1:0]),
    .in_right  (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_last   (in_tlast),
    .iss_s0_l  (s0_l),
    .iss_s1_l  (s1_l),
    .iss_s0_r  (s0_r),
    .iss_s1_r  (s1_r),
    .iss_frac  (frac),
    .iss_ctrl  (iss_ctrl)
  );

  lir_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_l (
    .clk   (clk),
    .en    (en),
    .s0    (s0_l),
    .s1    (s1_l),
    .frac  (frac),
    .base_r(base_l),
    .prod_r(prod_l)
  );

  lir_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_r (
    .clk   (clk),
    .en    (en),
    .s0    (s0_r),
    .s1    (s1_r),
    .frac  (frac),
    .base_r(base_rt),
    .prod_r(prod_rt)
  );

  lir_merge #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss_ctrl (iss_ctrl),
    .base_l   (base_l),
    .prod_l   (prod_l),
    .base_rt  (base_rt),
    .prod_rt  (prod_rt),
    .en       (en),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_left (res_l),
    .out_right(res_r),
    .out_last (out_tlast)
  );

  assign out_tdata = TDATA_W'({res_r, res_l});

endmodule
